// File: rtl/bwd_pkg.sv
`timescale 1ns / 1ps
package bwd_pkg;

	localparam int MAX_WORD_CHARS = 16;
	localparam int BUCKET_SLOTS   = 8;
	localparam int LETTER_ROWS    = 26;
	localparam int BUCKET_COLS    = 27;
	localparam int HYPHEN_COL     = 26;
	localparam int NUM_BUCKETS    = LETTER_ROWS * BUCKET_COLS;

	localparam int LEN_W     = $clog2(MAX_WORD_CHARS + 1);
	localparam int IDX_W     = $clog2(MAX_WORD_CHARS);
	localparam int FILL_W    = $clog2(BUCKET_SLOTS + 1);
	localparam int BKT_AW    = $clog2(NUM_BUCKETS);
	localparam int ENT_DEPTH = NUM_BUCKETS * BUCKET_SLOTS;
	localparam int ENT_AW    = $clog2(ENT_DEPTH);
	localparam int WORD_W    = MAX_WORD_CHARS * 8;
	localparam int ENT_W     = LEN_W + WORD_W;

	localparam logic [7:0] CH_HYPHEN = 8'h2d;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_NUL    = 8'h00;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_ADDED     = 4'd0,
		ST_FOUND     = 4'd1,
		ST_NOT_FOUND = 4'd2,
		ST_DUPLICATE = 4'd3,
		ST_EMPTY     = 4'd4,
		ST_TOO_SHORT = 4'd5,
		ST_TOO_LONG  = 4'd6,
		ST_INVALID   = 4'd7,
		ST_FULL      = 4'd8,
		ST_CLEARED   = 4'd9
	} status_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_INVALID    = 2'd1,
		ERR_OVERFLOW   = 2'd2,
		ERR_OVF_INVAL  = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		CMD_DIRECT = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_LOOKUP = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		B_INIT,
		B_IDLE,
		B_FILL,
		B_ERD,
		B_ECMP,
		B_CLR,
		B_OUT
	} bstate_t;

	typedef struct packed {
		kind_t                            kind;
		status_t                          status;
		logic [BKT_AW-1:0]                bucket;
		logic [LEN_W-1:0]                 len;
		logic [MAX_WORD_CHARS-1:0][7:0]   word;
	} cmd_t;

endpackage

// File: rtl/bwd_ram.sv
`timescale 1ns / 1ps
module bwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// File: rtl/bwd_front.sv
`timescale 1ns / 1ps
module bwd_front
	import bwd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [1:0] op,
	input  logic [7:0] char_in,
	input  logic       last,
	output logic       push,
	output cmd_t       cmd
);

	logic [MAX_WORD_CHARS-1:0][7:0] word_q, word_n;
	logic [LEN_W-1:0] cnt_q, cnt_n;
	logic             stop_q, stop_n;
	err_t             pend_q, pend_n;
	logic             letter, upper;
	logic [7:0]       d0, d1, row, col;

	always_comb begin
		upper  = (char_in >= 8'h41) && (char_in <= 8'h5a);
		letter = upper || ((char_in >= CH_A) && (char_in <= 8'h7a));
		word_n = word_q;
		cnt_n  = cnt_q;
		stop_n = stop_q;
		pend_n = pend_q;
		if (!(stop_q || pend_q == ERR_INVALID || pend_q == ERR_OVF_INVAL)) begin
			if (letter || (char_in == CH_HYPHEN && cnt_q != '0)) begin
				if (pend_q != ERR_OVERFLOW) begin
					if (cnt_q < LEN_W'(MAX_WORD_CHARS)) begin
						word_n[cnt_q[IDX_W-1:0]] = upper ? char_in + 8'd32 : char_in;
						cnt_n = cnt_q + 1'b1;
					end else begin
						pend_n = ERR_OVERFLOW;
					end
				end
			end else if (char_in == CH_SPACE || char_in == CH_TAB) begin
				stop_n = stop_q;
			end else if (char_in == CH_HASH || char_in == CH_NUL || char_in == CH_NL) begin
				stop_n = 1'b1;
			end else begin
				pend_n = (pend_q == ERR_OVERFLOW) ? ERR_OVF_INVAL : ERR_INVALID;
			end
		end

		d0  = word_n[0] - CH_A;
		d1  = word_n[1] - CH_A;
		row = (d0 < 8'(LETTER_ROWS)) ? d0 : 8'd0;
		if (word_n[1] == CH_HYPHEN || d1 >= 8'(LETTER_ROWS)) begin
			col = 8'(HYPHEN_COL);
		end else begin
			col = d1;
		end

		cmd.word   = word_n;
		cmd.len    = cnt_n;
		cmd.bucket = BKT_AW'(row) * BKT_AW'(BUCKET_COLS) + BKT_AW'(col);
		cmd.kind   = CMD_DIRECT;
		cmd.status = ST_EMPTY;
		unique case (op_t'(op))
			OP_CLEAR: begin
				cmd.kind = CMD_CLEAR;
				cmd.status = ST_CLEARED;
			end
			OP_INSERT: begin
				if (pend_n == ERR_INVALID) cmd.status = ST_INVALID;
				else if (pend_n != ERR_NONE) cmd.status = ST_TOO_LONG;
				else if (cnt_n == '0) cmd.status = ST_EMPTY;
				else if (cnt_n == LEN_W'(1)) cmd.status = ST_TOO_SHORT;
				else cmd.kind = CMD_INSERT;
			end
			OP_LOOKUP: begin
				if (pend_n == ERR_INVALID || pend_n == ERR_OVF_INVAL) cmd.status = ST_INVALID;
				else if (cnt_n >= LEN_W'(2) && word_n[1] == CH_HYPHEN) cmd.status = ST_INVALID;
				else if (pend_n == ERR_OVERFLOW) cmd.status = ST_TOO_LONG;
				else if (cnt_n == '0) cmd.status = ST_EMPTY;
				else if (cnt_n == LEN_W'(1)) cmd.status = ST_TOO_SHORT;
				else cmd.kind = CMD_LOOKUP;
			end
			default: cmd.kind = CMD_DIRECT;
		endcase
		push = accept && last && (op_t'(op) != OP_RSVD);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= word_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			stop_q <= 1'b0;
			pend_q <= ERR_NONE;
		end else if (accept) begin
			if (last) begin
				cnt_q  <= '0;
				stop_q <= 1'b0;
				pend_q <= ERR_NONE;
			end else begin
				cnt_q  <= cnt_n;
				stop_q <= stop_n;
				pend_q <= pend_n;
			end
		end
	end

endmodule

// File: rtl/bwd_queue.sv
`timescale 1ns / 1ps
module bwd_queue
	import bwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic in_ready,
	input  logic pop,
	output logic out_valid,
	output cmd_t out_cmd
);

	cmd_t       slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd   = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// File: rtl/bwd_back.sv
`timescale 1ns / 1ps
module bwd_back
	import bwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  cmd_t        q_cmd,
	output logic        pop,
	output logic        busy_init,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);

	bstate_t           state_q, state_n;
	cmd_t              cmd_q;
	logic [FILL_W-1:0] fill_q, s_q;
	logic [BKT_AW-1:0] idx_q;
	status_t           res_status_q;
	logic [BKT_AW-1:0] res_bucket_q;
	logic [2:0]        res_slot_q;
	logic [LEN_W-1:0]  res_len_q;

	logic              f_we, e_we;
	logic [BKT_AW-1:0] f_addr;
	logic [FILL_W-1:0] f_wdata, f_rdata;
	logic [ENT_AW-1:0] e_addr, e_base;
	logic [ENT_W-1:0]  e_wdata, e_rdata;
	logic              match;
	logic              fin;
	status_t           fin_status;
	logic [FILL_W-1:0] fin_slot;
	logic [MAX_WORD_CHARS-1:0][7:0] e_word;

	bwd_ram #(.WIDTH(FILL_W), .DEPTH(NUM_BUCKETS)) u_fill (
		.clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata)
	);

	bwd_ram #(.WIDTH(ENT_W), .DEPTH(ENT_DEPTH)) u_ent (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata)
	);

	assign e_base = ENT_AW'(cmd_q.bucket) * ENT_AW'(BUCKET_SLOTS);
	assign e_word = e_rdata[WORD_W-1:0];

	always_comb begin
		match = (e_rdata[ENT_W-1:WORD_W] == cmd_q.len);
		for (int i = 0; i < MAX_WORD_CHARS; i++) begin
			if ((LEN_W+1)'(i) < {1'b0, cmd_q.len} && e_word[i] != cmd_q.word[i]) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		state_n    = state_q;
		pop        = 1'b0;
		f_we       = 1'b0;
		f_addr     = cmd_q.bucket;
		f_wdata    = '0;
		e_we       = 1'b0;
		e_addr     = e_base + ENT_AW'(s_q);
		e_wdata    = {cmd_q.len, cmd_q.word};
		fin        = 1'b0;
		fin_status = cmd_q.status;
		fin_slot   = '0;
		unique case (state_q)
			B_INIT, B_CLR: begin
				f_we   = 1'b1;
				f_addr = idx_q;
				if (idx_q == BKT_AW'(NUM_BUCKETS - 1)) begin
					if (state_q == B_CLR) begin
						fin = 1'b1;
						fin_status = ST_CLEARED;
					end else begin
						state_n = B_IDLE;
					end
				end
			end
			B_IDLE: begin
				f_addr = q_cmd.bucket;
				if (q_valid) begin
					pop = 1'b1;
					unique case (q_cmd.kind)
						CMD_DIRECT: state_n = B_OUT;
						CMD_CLEAR:  state_n = B_CLR;
						default:    state_n = B_FILL;
					endcase
				end
			end
			B_FILL: state_n = B_ERD;
			B_ERD: begin
				if (s_q == fill_q) begin
					fin = 1'b1;
					if (cmd_q.kind == CMD_LOOKUP) begin
						fin_status = ST_NOT_FOUND;
					end else if (fill_q >= FILL_W'(BUCKET_SLOTS)) begin
						fin_status = ST_FULL;
					end else begin
						fin_status = ST_ADDED;
						fin_slot   = fill_q;
						e_we       = 1'b1;
						f_we       = 1'b1;
						f_wdata    = fill_q + 1'b1;
					end
				end else begin
					state_n = B_ECMP;
				end
			end
			B_ECMP: begin
				if (match) begin
					fin = 1'b1;
					fin_status = (cmd_q.kind == CMD_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
					fin_slot = s_q;
				end else begin
					state_n = B_ERD;
				end
			end
			B_OUT: begin
				if (m_tready) state_n = B_IDLE;
			end
			default: state_n = B_IDLE;
		endcase
		if (fin) state_n = B_OUT;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q        <= q_cmd;
			res_status_q <= q_cmd.status;
			res_bucket_q <= '0;
			res_slot_q   <= '0;
			res_len_q    <= (q_cmd.kind == CMD_CLEAR) ? '0 : q_cmd.len;
		end
		if (fin) begin
			res_status_q <= fin_status;
			res_slot_q   <= 3'(fin_slot);
			if (fin_status != ST_CLEARED) res_bucket_q <= cmd_q.bucket;
		end
		if (state_q == B_FILL) fill_q <= f_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_INIT;
			idx_q   <= '0;
			s_q     <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == B_INIT || state_q == B_CLR) idx_q <= idx_q + 1'b1;
			else idx_q <= '0;
			if (state_q == B_FILL) s_q <= '0;
			else if (state_q == B_ECMP) s_q <= s_q + 1'b1;
		end
	end

	assign busy_init = (state_q == B_INIT);
	assign m_tvalid  = (state_q == B_OUT);
	assign m_tdata   = {2'b00, 5'(res_len_q), res_slot_q, 10'(res_bucket_q), res_status_q};

	a_no_pop_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_INIT) |-> !pop) else $error("pop during reset sweep");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		f_we |-> (f_wdata <= FILL_W'(BUCKET_SLOTS))) else $error("fill count overflow");
	a_ent_write: assert property (@(posedge clk) disable iff (!arst_n)
		e_we |-> (state_q == B_ERD && fill_q < FILL_W'(BUCKET_SLOTS)))
		else $error("entry write outside insert");
	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (state_q != B_IDLE)) else $error("pop without work");

endmodule

// File: rtl/bucketed_word_dictionary.sv
`timescale 1ns / 1ps
// Word dictionary fed one character per transfer on the slave stream.
// s_tdata carries the character, s_tuser the operation (insert, look up,
// clear) and s_tlast marks the end of the line, where the operation runs.
// Each line that ends with a valid operation gives one word on the master
// stream with status, bucket, slot and collected length.
// A front end takes one character per cycle while s_tready is high and queues a finished line
// for the back end, which walks the bucket in the memories.
// For a direct answer, the line passes through the queue and the back end
// before m_tvalid rises. A bucket search reads the fill count, then reads
// and compares the slots in turn until one matches or all filled ones are done.
// A clear sweeps the fill memory over all 702 buckets before its result rises.
// After reset the fill memory is swept and s_tready stays low until the sweep ends.
// While the master side stalls, the front end keeps taking characters until
// the two-line queue is full.
module bucketed_word_dictionary
	import bwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // char_in[7:0]
	input  logic [1:0]  s_tuser,  // op[1:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // status[3:0], bucket[13:4], slot[16:14], word_length[21:17]
);

	logic accept, push, q_ready, q_valid, pop, busy_init;
	cmd_t push_cmd, q_cmd;

	assign s_tready = q_ready && !busy_init;
	assign accept   = s_tvalid && s_tready;

	bwd_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept), .op(s_tuser), .char_in(s_tdata),
		.last(s_tlast), .push(push), .cmd(push_cmd)
	);

	bwd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_cmd(push_cmd), .in_ready(q_ready),
		.pop(pop), .out_valid(q_valid), .out_cmd(q_cmd)
	);

	bwd_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_cmd(q_cmd), .pop(pop),
		.busy_init(busy_init), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule
